FILE: rtl/core/ezr_pkg.sv
// Package for the ZYX Euler-to-rotation-matrix block: payload types,
// CORDIC constants and the arctangent table. No dependencies.
`default_nettype none
package ezr_pkg;
  localparam int ANGLE_BITS   = 16;
  localparam int ENTRY_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 30;
  localparam int WORK_FRAC    = 30;
  localparam int WW           = 34;

  localparam logic signed [WW-1:0] GAIN_Q30    = 34'sh026DD3B6A;
  localparam logic signed [WW-1:0] HALF_PI_Q30 = 34'sh06487ED51;
  localparam logic signed [WW-1:0] PI_Q30      = 34'sh0C90FDAA2;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] roll_angle;
  } in_word_t;

  typedef struct packed {
    logic signed [ENTRY_BITS-1:0] row1_col1;
    logic signed [ENTRY_BITS-1:0] row1_col2;
    logic signed [ENTRY_BITS-1:0] row1_col3;
    logic signed [ENTRY_BITS-1:0] row2_col1;
    logic signed [ENTRY_BITS-1:0] row2_col2;
    logic signed [ENTRY_BITS-1:0] row2_col3;
    logic signed [ENTRY_BITS-1:0] row3_col1;
    logic signed [ENTRY_BITS-1:0] row3_col2;
    logic signed [ENTRY_BITS-1:0] row3_col3;
  } out_word_t;

  // CORDIC state for one angle as it moves down the cell row
  typedef struct packed {
    logic signed [WW-1:0] x;
    logic signed [WW-1:0] y;
    logic signed [WW-1:0] z;
    logic                 cneg;
  } rot_t;

  function automatic logic signed [WW-1:0] atan_q30(input int i);
    logic signed [WW-1:0] t;
    case (i)
      0: t = 34'sh03243F6A8;  1: t = 34'sh01DAC6705;  2: t = 34'sh00FADBAFC;
      3: t = 34'sh007F56EA6;  4: t = 34'sh003FEAB76;  5: t = 34'sh001FFD55B;
      6: t = 34'sh000FFFAAA;  7: t = 34'sh0007FFF55;  8: t = 34'sh0003FFFEA;
      9: t = 34'sh0001FFFFD; 10: t = 34'sh0000FFFFF; 11: t = 34'sh00007FFFF;
      12: t = 34'sh00003FFFF; 13: t = 34'sh00001FFFF; 14: t = 34'sh00000FFFF;
      15: t = 34'sh000007FFF; 16: t = 34'sh000003FFF; 17: t = 34'sh000001FFF;
      18: t = 34'sh000000FFF; 19: t = 34'sh0000007FF; 20: t = 34'sh0000003FF;
      21: t = 34'sh0000001FF; 22: t = 34'sh0000000FF; 23: t = 34'sh00000007F;
      24: t = 34'sh00000003F; 25: t = 34'sh00000001F; 26: t = 34'sh00000000F;
      27: t = 34'sh000000008; 28: t = 34'sh000000004; 29: t = 34'sh000000002;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/ezr_cell.sv
// One CORDIC micro-rotation cell for three angles at once, registered.
// Depends on ezr_pkg.
`default_nettype none
module ezr_cell #(
  parameter int STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire ezr_pkg::rot_t yi,
  input  wire ezr_pkg::rot_t pi_,
  input  wire ezr_pkg::rot_t ri,
  output ezr_pkg::rot_t      yo,
  output ezr_pkg::rot_t      po,
  output ezr_pkg::rot_t      ro
);
  function automatic ezr_pkg::rot_t turn(input ezr_pkg::rot_t a);
    ezr_pkg::rot_t b;
    logic signed [ezr_pkg::WW-1:0] dx, dy, t;
    dx = a.y >>> STEP;
    dy = a.x >>> STEP;
    t  = ezr_pkg::atan_q30(STEP);
    b  = a;
    if (!a.z[ezr_pkg::WW-1]) begin
      b.x = a.x - dx; b.y = a.y + dy; b.z = a.z - t;
    end else begin
      b.x = a.x + dx; b.y = a.y - dy; b.z = a.z + t;
    end
    return b;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      yo <= turn(yi);
      po <= turn(pi_);
      ro <= turn(ri);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/ezr_matrix.sv
// Product and rounding stages: sine/cosine in Q30 to nine Q1.x entries.
// Four register stages. Depends on ezr_pkg.
`default_nettype none
module ezr_matrix #(
  parameter int ENTRY_BITS = ezr_pkg::ENTRY_BITS
) (
  input  wire logic                              clk,
  input  wire logic [3:0]                        en,
  input  wire logic signed [ezr_pkg::WW-1:0]     sy, cy, sp, cp, sr, cr,
  output logic signed [9*ENTRY_BITS-1:0]         ent
);
  localparam int W = ezr_pkg::WW;
  localparam int SH = 32 - ENTRY_BITS;

  function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [2*W-1:0] p;
    p = a * b + (64'sd1 <<< 29);
    return W'(p >>> 30);
  endfunction

  function automatic logic signed [ENTRY_BITS-1:0] to_entry(input logic signed [W-1:0] v);
    logic signed [W:0] r, lim;
    r = {v[W-1], v};
    if (SH > 0) r = (r + ((W+1)'(1) <<< (SH > 0 ? SH-1 : 0))) >>> SH;
    lim = (W+1)'(1) <<< (ENTRY_BITS-2);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[ENTRY_BITS-1:0];
  endfunction

  // stage 1: pairwise products
  logic signed [W-1:0] srsp, crsp, cpcy, crsy, srsy, cpsy, crcy, srcy, srcp, crcp, nsp;
  logic signed [W-1:0] cy1, sy1;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      srsp <= qmul(sr, sp); crsp <= qmul(cr, sp);
      cpcy <= qmul(cp, cy); crsy <= qmul(cr, sy);
      srsy <= qmul(sr, sy); cpsy <= qmul(cp, sy);
      crcy <= qmul(cr, cy); srcy <= qmul(sr, cy);
      srcp <= qmul(sr, cp); crcp <= qmul(cr, cp);
      nsp  <= -sp; cy1 <= cy; sy1 <= sy;
    end
  end

  // stage 2: triple products
  logic signed [W-1:0] a12, a13, a22, a23;
  logic signed [W-1:0] b11, b12, b13, b21, b22, b23, b31, b32, b33;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      a12 <= qmul(srsp, cy1); a13 <= qmul(crsp, cy1);
      a22 <= qmul(srsp, sy1); a23 <= qmul(crsp, sy1);
      b11 <= cpcy; b12 <= crsy; b13 <= srsy; b21 <= cpsy;
      b22 <= crcy; b23 <= srcy; b31 <= nsp; b32 <= srcp; b33 <= crcp;
    end
  end

  // stage 3: sums
  logic signed [W-1:0] s [9];
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s[0] <= b11;       s[1] <= a12 - b12; s[2] <= b13 + a13;
      s[3] <= b21;       s[4] <= b22 + a22; s[5] <= a23 - b23;
      s[6] <= b31;       s[7] <= b32;       s[8] <= b33;
    end
  end

  // stage 4: round and clamp
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 9; k++)
        ent[(8-k)*ENTRY_BITS +: ENTRY_BITS] <= to_entry(s[k]);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/euler_zyx_to_rotation_matrix_top.sv
// ZYX Euler angles to rotation matrix: folding stage, CORDIC cell row,
// product pipeline. Depends on ezr_pkg, ezr_cell, ezr_matrix.
//
// Usage: present yaw, pitch and roll (signed Q2.13 radians) on in_data with
// in_valid; the nine matrix entries (signed Q1.14) leave on out_data with
// out_valid. Both channels use valid/ready.
// Throughput: one word per clock while the output is not stalled; the row of
// CORDIC_STEPS cells and the product stages are all registered, so a new word
// enters every cycle unless out_ready holds the pipeline. Stages: fold stage,
// one cell per iteration, four product stages, output register.
// Stall: when out_ready is low while out_valid is set the whole pipeline holds;
// in_ready then follows the last stage, so a word already finished waits in the
// output register and nothing is lost. Reset clears all valid bits; no data
// reset.
`default_nettype none
module euler_zyx_to_rotation_matrix_top #(
  parameter int CORDIC_STEPS = ezr_pkg::CORDIC_STEPS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ezr_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ezr_pkg::out_word_t     out_data
);
  localparam int W  = ezr_pkg::WW;
  localparam int NS = (CORDIC_STEPS < ezr_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                         : ezr_pkg::TABLE_LEN;
  localparam int DEPTH = NS + 6;

  logic [DEPTH-1:0] vld;
  logic             adv;

  // pipeline moves when the output slot is free or being taken
  assign adv       = !vld[DEPTH-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  function automatic ezr_pkg::rot_t fold(input logic signed [ezr_pkg::ANGLE_BITS-1:0] a);
    ezr_pkg::rot_t r;
    logic signed [W-1:0] z;
    z = W'(a) <<< (30 + 3 - ezr_pkg::ANGLE_BITS);
    r.cneg = 1'b0;
    if (z > ezr_pkg::HALF_PI_Q30) begin
      z = ezr_pkg::PI_Q30 - z; r.cneg = 1'b1;
    end else if (z < -ezr_pkg::HALF_PI_Q30) begin
      z = -ezr_pkg::PI_Q30 - z; r.cneg = 1'b1;
    end
    r.x = ezr_pkg::GAIN_Q30;
    r.y = '0;
    r.z = z;
    return r;
  endfunction

  ezr_pkg::rot_t yc [NS+1];
  ezr_pkg::rot_t pc [NS+1];
  ezr_pkg::rot_t rc [NS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      yc[0] <= fold(in_data.yaw_angle);
      pc[0] <= fold(in_data.pitch_angle);
      rc[0] <= fold(in_data.roll_angle);
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_cell
    ezr_cell #(.STEP(g)) u_cell (
      .clk(clk), .en(adv),
      .yi(yc[g]), .pi_(pc[g]), .ri(rc[g]),
      .yo(yc[g+1]), .po(pc[g+1]), .ro(rc[g+1])
    );
  end

  function automatic logic signed [W-1:0] cosv(input ezr_pkg::rot_t r);
    return r.cneg ? -r.x : r.x;
  endfunction

  logic signed [9*ezr_pkg::ENTRY_BITS-1:0] ent;

  ezr_matrix #(.ENTRY_BITS(ezr_pkg::ENTRY_BITS)) u_mat (
    .clk(clk), .en({4{adv}}),
    .sy(yc[NS].y), .cy(cosv(yc[NS])),
    .sp(pc[NS].y), .cp(cosv(pc[NS])),
    .sr(rc[NS].y), .cr(cosv(rc[NS])),
    .ent(ent)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= ent;
    end
  end
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for euler_zyx_to_rotation_matrix_top: directed table plus random angles,
// each output word checked against a Q30 CORDIC predictor. Depends on ezr_pkg and the top.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  localparam int LATENCY  = ezr_pkg::CORDIC_STEPS + 6;
  localparam int N_RANDOM = 1000;
  localparam int N_DIRECT = 16;
  localparam int EB       = ezr_pkg::ENTRY_BITS;
  localparam int AB       = ezr_pkg::ANGLE_BITS;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  ezr_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ezr_pkg::out_word_t out_data;

  euler_zyx_to_rotation_matrix_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ezr_pkg::out_word_t matrix_q[$];
  int                 errors = 0;
  int                 words_in = 0;
  int                 words_out = 0;
  bit                 hold_off = 1'b0;

  typedef logic signed [63:0] q_t;

  // Directed rows: angles, and an expected matrix where it is obvious.
  typedef struct {
    logic signed [15:0] y, p, r;
    bit                 has_exp;
    ezr_pkg::out_word_t exp;
  } dir_row_t;
  dir_row_t dir_tab[N_DIRECT];

  function automatic q_t fshift(q_t v, int s);
    return v >>> s;
  endfunction

  function automatic q_t qmul(q_t a, q_t b);
    return fshift(a * b + (q_t'(1) <<< (ezr_pkg::WORK_FRAC - 1)), ezr_pkg::WORK_FRAC);
  endfunction

  function automatic logic signed [EB-1:0] to_entry(q_t v);
    q_t r;
    q_t lim;
    lim = q_t'(1) <<< (EB - 2);
    r = v;
    if (EB < 32) r = fshift(v + (q_t'(1) <<< (31 - EB)), 32 - EB);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[EB-1:0];
  endfunction

  function automatic void sine_cosine(input logic signed [AB-1:0] ang,
                                      output q_t s, output q_t c);
    q_t x, y, z, dx, dy, t;
    bit cneg;
    cneg = 1'b0;
    z = q_t'(ang) <<< (ezr_pkg::WORK_FRAC + 3 - AB);
    if (z > q_t'(ezr_pkg::HALF_PI_Q30)) begin
      z = q_t'(ezr_pkg::PI_Q30) - z;
      cneg = 1'b1;
    end else if (z < -q_t'(ezr_pkg::HALF_PI_Q30)) begin
      z = -q_t'(ezr_pkg::PI_Q30) - z;
      cneg = 1'b1;
    end
    x = q_t'(ezr_pkg::GAIN_Q30);
    y = '0;
    for (int i = 0; i < ezr_pkg::CORDIC_STEPS && i < ezr_pkg::TABLE_LEN; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      t = q_t'(ezr_pkg::atan_q30(i));
      if (z >= 0) begin
        x -= dx; y += dy; z -= t;
      end else begin
        x += dx; y -= dy; z += t;
      end
    end
    s = y;
    c = cneg ? -x : x;
  endfunction

  function automatic ezr_pkg::out_word_t rotation_of(ezr_pkg::in_word_t w);
    q_t sy, cy, sp, cp, sr, cr, srsp, crsp;
    ezr_pkg::out_word_t m;
    sine_cosine(w.yaw_angle, sy, cy);
    sine_cosine(w.pitch_angle, sp, cp);
    sine_cosine(w.roll_angle, sr, cr);
    srsp = qmul(sr, sp);
    crsp = qmul(cr, sp);
    m.row1_col1 = to_entry(qmul(cp, cy));
    m.row1_col2 = to_entry(qmul(srsp, cy) - qmul(cr, sy));
    m.row1_col3 = to_entry(qmul(sr, sy) + qmul(crsp, cy));
    m.row2_col1 = to_entry(qmul(cp, sy));
    m.row2_col2 = to_entry(qmul(cr, cy) + qmul(srsp, sy));
    m.row2_col3 = to_entry(qmul(crsp, sy) - qmul(sr, cy));
    m.row3_col1 = to_entry(-sp);
    m.row3_col2 = to_entry(qmul(sr, cp));
    m.row3_col3 = to_entry(qmul(cr, cp));
    return m;
  endfunction

  task automatic report_line(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task automatic report_mismatch(string what, logic signed [EB-1:0] got,
                                 logic signed [EB-1:0] want);
    report_line($sformatf("word %0d %s: got %0d want %0d", words_out, what, got, want));
  endtask

  task automatic send_word(ezr_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_in++;
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF - 16'($urandom_range(0, 3));
      1: return 16'sh8000 + 16'($urandom_range(0, 3));
      2: return 16'($urandom_range(0, 64)) - 16'sd32;
      3: return 16'sd12868 + 16'($urandom_range(0, 8)) - 16'sd4;
      4: return -16'sd12868 + 16'($urandom_range(0, 8)) - 16'sd4;
      default: return 16'($urandom);
    endcase
  endfunction

  // Predict at accept time so the queue follows pipeline order.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) matrix_q.push_back(rotation_of(in_data));
  end

  always @(posedge clk) begin
    ezr_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (matrix_q.size() == 0) begin
        report_line($sformatf("unexpected output word %0d", words_out));
      end else begin
        want = matrix_q.pop_front();
        if (out_data.row1_col1 !== want.row1_col1)
          report_mismatch("r1c1", out_data.row1_col1, want.row1_col1);
        if (out_data.row1_col2 !== want.row1_col2)
          report_mismatch("r1c2", out_data.row1_col2, want.row1_col2);
        if (out_data.row1_col3 !== want.row1_col3)
          report_mismatch("r1c3", out_data.row1_col3, want.row1_col3);
        if (out_data.row2_col1 !== want.row2_col1)
          report_mismatch("r2c1", out_data.row2_col1, want.row2_col1);
        if (out_data.row2_col2 !== want.row2_col2)
          report_mismatch("r2c2", out_data.row2_col2, want.row2_col2);
        if (out_data.row2_col3 !== want.row2_col3)
          report_mismatch("r2c3", out_data.row2_col3, want.row2_col3);
        if (out_data.row3_col1 !== want.row3_col1)
          report_mismatch("r3c1", out_data.row3_col1, want.row3_col1);
        if (out_data.row3_col2 !== want.row3_col2)
          report_mismatch("r3c2", out_data.row3_col2, want.row3_col2);
        if (out_data.row3_col3 !== want.row3_col3)
          report_mismatch("r3c3", out_data.row3_col3, want.row3_col3);
      end
      words_out++;
    end
  end

  // Receiver stall pattern, with one long hold-off to back up the pipeline.
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if (words_out < 100 || (words_out > 600 && words_out < 700)) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    repeat (300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (3 * LATENCY + 40) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    ezr_pkg::in_word_t w;
    int burst;
    for (int i = 0; i < N_DIRECT; i++) dir_tab[i].has_exp = 1'b0;
    // Zero angles give the identity.
    dir_tab[0] = '{0, 0, 0, 1, '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}};
    dir_tab[1] = '{16'sh7FFF, 0, 0, 0, '0};
    dir_tab[2] = '{16'sh8000, 0, 0, 0, '0};
    dir_tab[3] = '{0, 16'sh7FFF, 0, 0, '0};
    dir_tab[4] = '{0, 16'sh8000, 0, 0, '0};
    dir_tab[5] = '{0, 0, 16'sh7FFF, 0, '0};
    dir_tab[6] = '{0, 0, 16'sh8000, 0, '0};
    dir_tab[7] = '{16'sd12868, 16'sd12868, 16'sd12868, 0, '0};
    dir_tab[8] = '{-16'sd12868, -16'sd12868, -16'sd12868, 0, '0};
    dir_tab[9] = '{16'sd25736, 16'sd25736, 16'sd25736, 0, '0};
    dir_tab[10] = '{-16'sd25736, -16'sd25736, -16'sd25736, 0, '0};
    dir_tab[11] = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, '0};
    dir_tab[12] = '{16'sh8000, 16'sh8000, 16'sh8000, 0, '0};
    dir_tab[13] = '{16'sd6434, -16'sd6434, 16'sd1, 0, '0};
    dir_tab[14] = '{-16'sd1, 16'sd12869, -16'sd12869, 0, '0};
    dir_tab[15] = '{16'sh5555, 16'shAAAA, 16'sh0F0F, 0, '0};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < N_DIRECT; i++) begin
      w = '{dir_tab[i].y, dir_tab[i].p, dir_tab[i].r};
      if (dir_tab[i].has_exp && rotation_of(w) !== dir_tab[i].exp)
        report_line($sformatf("predictor disagrees with table row %0d", i));
      send_word(w);
    end
    while (words_in < N_DIRECT + N_RANDOM) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        w.yaw_angle   = rand_angle();
        w.pitch_angle = rand_angle();
        w.roll_angle  = rand_angle();
        send_word(w);
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    $display("sent %0d angle triples (table extremes, folds, random), checked %0d matrices",
             words_in, words_out);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire

FILE: euler_zyx_to_rotation_matrix_top.f
rtl/core/ezr_pkg.sv
rtl/core/ezr_cell.sv
rtl/core/ezr_matrix.sv
rtl/core/euler_zyx_to_rotation_matrix_top.sv
tb/sv/tb.sv
